@@ hdl/rational_arithmetic_unit_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rational arithmetic unit
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, quiet during rst
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Types, codes and helpers for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FIELD_W     = 32;
  localparam int MAG_W       = 32;
  localparam int WIDE_W      = 64;
  localparam int SHIFT_W     = 6;
  localparam int DEN_OUT_W   = 31;
  localparam int IN_W        = 136;
  localparam int OUT_W       = 72;

  localparam logic [WIDE_W-1:0] HALF_RANGE = WIDE_W'(1) << (VALUE_WIDTH - 1);

  localparam logic [3:0] MODE_REDUCE = 4'd0;
  localparam logic [3:0] MODE_ADD    = 4'd1;
  localparam logic [3:0] MODE_SUB    = 4'd2;
  localparam logic [3:0] MODE_MUL    = 4'd3;
  localparam logic [3:0] MODE_DIV    = 4'd4;
  localparam logic [3:0] MODE_EQ     = 4'd5;
  localparam logic [3:0] MODE_NE     = 4'd6;
  localparam logic [3:0] MODE_GT     = 4'd7;
  localparam logic [3:0] MODE_LT     = 4'd8;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_OVF  = 2'd2;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_R = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVX,
    ST_DIVY,
    ST_RET,
    ST_MUL,
    ST_COMB,
    ST_FIN,
    ST_OUT
  } state_t;

  // sign of a field read as VALUE_WIDTH-bit two's complement
  function automatic logic fld_neg(input logic [FIELD_W-1:0] f);
    return f[VALUE_WIDTH-1];
  endfunction

  // magnitude of a field read as VALUE_WIDTH-bit two's complement
  function automatic logic [MAG_W-1:0] fld_mag(input logic [FIELD_W-1:0] f);
    logic [VALUE_WIDTH-1:0] x;
    x = f[VALUE_WIDTH-1:0];
    if (x[VALUE_WIDTH-1]) begin
      x = -x;
    end
    return MAG_W'(x);
  endfunction

endpackage

`default_nettype wire

@@ hdl/rational_arithmetic_unit_top.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Signed fraction reduce / add / sub / mul / div / compare with gcd reduction.
// ----------------------------------------------------------------------------
//  channel | dir | fields (low bit up)
//  s_*     | in  | mode, a_num, a_den, b_num, b_den
//  m_*     | out | res_num, res_den, compare_true, status
//
//  An item's run time is set by the shared 64-bit subtract/shift unit:
//  binary gcd (one subtract or shift a cycle) and two restoring divisions
//  for each of a, b and (add/sub/mul/div only) the result; reduce does only a;
//  a zero numerator skips its gcd and divisions.
//  Rejected items (bad mode, zero denominator, divide by zero) skip the datapath.
//  s_tready is high only when idle; a result may wait in the output register
//  while the next item is taken. rst is synchronous, active high.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // mode[3:0], a_num[35:4], a_den[67:36], b_num[99:68], b_den[131:100], pad
  input  wire logic [rau_pkg::IN_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // res_num[31:0], res_den[62:32], compare_true[63], status[65:64], pad
  output logic [rau_pkg::OUT_W-1:0]      m_tdata
);

  rau_pkg::state_t state, state_next;

  logic [3:0]                    in_mode;
  logic [rau_pkg::FIELD_W-1:0]   in_an, in_ad, in_bn, in_bd;
  logic [rau_pkg::MAG_W-1:0]     anm, adm, bnm, bdm;
  logic                          in_err;

  logic [3:0]                    mode_r;
  logic [1:0]                    phase;
  logic                          aneg, bneg, rneg;
  logic [rau_pkg::MAG_W-1:0]     amag, aden, bmag, bden;
  logic [rau_pkg::WIDE_W-1:0]    x_reg, y_reg, u, v, d, rem;
  logic [rau_pkg::SHIFT_W-1:0]   k, cnt;
  logic [1:0]                    mcnt;
  logic [rau_pkg::WIDE_W-1:0]    prod0, prod1, prod2;
  logic [rau_pkg::MAG_W-1:0]     mul_a, mul_b;
  logic [rau_pkg::WIDE_W-1:0]    mul_p;

  logic [rau_pkg::FIELD_W-1:0]   pk_num;
  logic [rau_pkg::DEN_OUT_W-1:0] pk_den;
  logic                          pk_cmp;
  logic [1:0]                    pk_st;

  logic [rau_pkg::WIDE_W:0]      rem2x, rem2y;
  logic                          gex, gey;
  logic                          div_last;
  logic                          is_cmp;

  logic signed [rau_pkg::WIDE_W:0] cx, cy;
  logic                          cmp_t;
  logic                          beff, sneg;
  logic [rau_pkg::WIDE_W-1:0]    smag, c_num, c_den;
  logic                          c_neg;
  logic                          fin_ok;
  logic [rau_pkg::WIDE_W-1:0]    fin_num;
  logic                          out_free;

  assign in_mode = s_tdata[3:0];
  assign in_an   = s_tdata[35:4];
  assign in_ad   = s_tdata[67:36];
  assign in_bn   = s_tdata[99:68];
  assign in_bd   = s_tdata[131:100];
  assign anm = rau_pkg::fld_mag(in_an);
  assign adm = rau_pkg::fld_mag(in_ad);
  assign bnm = rau_pkg::fld_mag(in_bn);
  assign bdm = rau_pkg::fld_mag(in_bd);

  assign in_err = (in_mode > rau_pkg::MODE_LT) || (adm == '0) ||
                  ((in_mode != rau_pkg::MODE_REDUCE) && (bdm == '0)) ||
                  ((in_mode == rau_pkg::MODE_DIV) && (bnm == '0));

  assign s_tready = (state == rau_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign is_cmp   = (mode_r >= rau_pkg::MODE_EQ);

  // shared restoring divider step
  assign rem2x = {rem, x_reg[rau_pkg::WIDE_W-1]};
  assign rem2y = {rem, y_reg[rau_pkg::WIDE_W-1]};
  assign gex   = (rem2x >= {1'b0, d});
  assign gey   = (rem2y >= {1'b0, d});
  assign div_last = (cnt == {rau_pkg::SHIFT_W{1'b1}});

  // one multiplier, three products in turn
  always_comb begin
    case (mcnt)
      2'd0: begin
        mul_a = amag;
        mul_b = (mode_r == rau_pkg::MODE_MUL) ? bmag : bden;
      end
      2'd1: begin
        mul_a = bmag;
        mul_b = aden;
      end
      default: begin
        mul_a = aden;
        mul_b = bden;
      end
    endcase
  end
  assign mul_p = rau_pkg::WIDE_W'(mul_a) * rau_pkg::WIDE_W'(mul_b);

  // combine products into the unreduced result
  always_comb begin
    cx = aneg ? -$signed({1'b0, prod0}) : $signed({1'b0, prod0});
    cy = bneg ? -$signed({1'b0, prod1}) : $signed({1'b0, prod1});
    case (mode_r)
      rau_pkg::MODE_EQ: cmp_t = (cx == cy);
      rau_pkg::MODE_NE: cmp_t = (cx != cy);
      rau_pkg::MODE_GT: cmp_t = (cx > cy);
      default:          cmp_t = (cx < cy);
    endcase
    beff = (mode_r == rau_pkg::MODE_SUB) ? !bneg : bneg;
    if (aneg == beff) begin
      sneg = aneg;
      smag = prod0 + prod1;
    end else if (prod0 >= prod1) begin
      sneg = aneg;
      smag = prod0 - prod1;
    end else begin
      sneg = beff;
      smag = prod1 - prod0;
    end
    case (mode_r)
      rau_pkg::MODE_ADD, rau_pkg::MODE_SUB: begin
        c_num = smag;
        c_den = prod2;
        c_neg = sneg;
      end
      rau_pkg::MODE_MUL: begin
        c_num = prod0;
        c_den = prod2;
        c_neg = aneg ^ bneg;
      end
      default: begin
        c_num = prod0;
        c_den = prod1;
        c_neg = aneg ^ bneg;
      end
    endcase
  end

  assign fin_ok = (y_reg <= rau_pkg::HALF_RANGE - 1'b1) &&
                  (rneg ? (x_reg <= rau_pkg::HALF_RANGE)
                        : (x_reg <= rau_pkg::HALF_RANGE - 1'b1));
  assign fin_num = rneg ? -x_reg : x_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rau_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = in_err ? rau_pkg::ST_OUT : rau_pkg::ST_GCD;
        end
      end
      rau_pkg::ST_GCD: begin
        if (x_reg == '0) begin
          state_next = rau_pkg::ST_RET;
        end else if (u == '0) begin
          state_next = rau_pkg::ST_DIVX;
        end
      end
      rau_pkg::ST_DIVX: if (div_last) state_next = rau_pkg::ST_DIVY;
      rau_pkg::ST_DIVY: if (div_last) state_next = rau_pkg::ST_RET;
      rau_pkg::ST_RET: begin
        case (phase)
          rau_pkg::PH_A: state_next = (mode_r == rau_pkg::MODE_REDUCE) ?
                                      rau_pkg::ST_FIN : rau_pkg::ST_GCD;
          rau_pkg::PH_B: state_next = rau_pkg::ST_MUL;
          default:       state_next = rau_pkg::ST_FIN;
        endcase
      end
      rau_pkg::ST_MUL:  if (mcnt == 2'd2) state_next = rau_pkg::ST_COMB;
      rau_pkg::ST_COMB: state_next = is_cmp ? rau_pkg::ST_OUT : rau_pkg::ST_GCD;
      rau_pkg::ST_FIN:  state_next = rau_pkg::ST_OUT;
      rau_pkg::ST_OUT:  if (out_free) state_next = rau_pkg::ST_IDLE;
      default:          state_next = rau_pkg::ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == rau_pkg::ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rau_pkg::ST_OUT && out_free) begin
      m_tdata <= {{(rau_pkg::OUT_W - 66){1'b0}}, pk_st, pk_cmp, pk_den, pk_num};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      rau_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          mode_r <= in_mode;
          aneg   <= (anm != '0) && (rau_pkg::fld_neg(in_an) ^ rau_pkg::fld_neg(in_ad));
          bneg   <= (bnm != '0) && (rau_pkg::fld_neg(in_bn) ^ rau_pkg::fld_neg(in_bd));
          bmag   <= bnm;
          bden   <= bdm;
          x_reg  <= rau_pkg::WIDE_W'(anm);
          y_reg  <= rau_pkg::WIDE_W'(adm);
          u      <= rau_pkg::WIDE_W'(anm);
          v      <= rau_pkg::WIDE_W'(adm);
          k      <= '0;
          phase  <= rau_pkg::PH_A;
          pk_num <= '0;
          pk_den <= '0;
          pk_cmp <= 1'b0;
          pk_st  <= rau_pkg::STAT_ZERO;
        end
      end
      rau_pkg::ST_GCD: begin
        if (x_reg == '0) begin
          y_reg <= rau_pkg::WIDE_W'(1);
        end else if (u == '0) begin
          // gcd = v << k; strip the power of two, divide by the odd part
          x_reg <= x_reg >> k;
          y_reg <= y_reg >> k;
          d     <= v;
          rem   <= '0;
          cnt   <= '0;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u >= v) begin
          u <= u - v;
        end else begin
          v <= v - u;
        end
      end
      rau_pkg::ST_DIVX: begin
        // remainder restarts at zero for the denominator pass
        rem   <= div_last ? '0 :
                 (gex ? rau_pkg::WIDE_W'(rem2x - {1'b0, d}) : rau_pkg::WIDE_W'(rem2x));
        x_reg <= {x_reg[rau_pkg::WIDE_W-2:0], gex};
        cnt   <= cnt + 1'b1;
      end
      rau_pkg::ST_DIVY: begin
        rem   <= gey ? rau_pkg::WIDE_W'(rem2y - {1'b0, d}) : rau_pkg::WIDE_W'(rem2y);
        y_reg <= {y_reg[rau_pkg::WIDE_W-2:0], gey};
        cnt   <= cnt + 1'b1;
      end
      rau_pkg::ST_RET: begin
        case (phase)
          rau_pkg::PH_A: begin
            amag <= x_reg[rau_pkg::MAG_W-1:0];
            aden <= y_reg[rau_pkg::MAG_W-1:0];
            rneg <= aneg;
            if (mode_r != rau_pkg::MODE_REDUCE) begin
              x_reg <= rau_pkg::WIDE_W'(bmag);
              y_reg <= rau_pkg::WIDE_W'(bden);
              u     <= rau_pkg::WIDE_W'(bmag);
              v     <= rau_pkg::WIDE_W'(bden);
              k     <= '0;
              phase <= rau_pkg::PH_B;
            end
          end
          rau_pkg::PH_B: begin
            bmag <= x_reg[rau_pkg::MAG_W-1:0];
            bden <= y_reg[rau_pkg::MAG_W-1:0];
            mcnt <= 2'd0;
          end
          default: begin
          end
        endcase
      end
      rau_pkg::ST_MUL: begin
        case (mcnt)
          2'd0:    prod0 <= mul_p;
          2'd1:    prod1 <= mul_p;
          default: prod2 <= mul_p;
        endcase
        mcnt <= mcnt + 1'b1;
      end
      rau_pkg::ST_COMB: begin
        if (is_cmp) begin
          pk_num <= '0;
          pk_den <= rau_pkg::DEN_OUT_W'(1);
          pk_cmp <= cmp_t;
          pk_st  <= rau_pkg::STAT_OK;
        end else begin
          x_reg <= c_num;
          y_reg <= c_den;
          u     <= c_num;
          v     <= c_den;
          k     <= '0;
          rneg  <= c_neg && (c_num != '0);
          phase <= rau_pkg::PH_R;
        end
      end
      rau_pkg::ST_FIN: begin
        pk_cmp <= 1'b0;
        if (fin_ok) begin
          pk_num <= fin_num[rau_pkg::FIELD_W-1:0];
          pk_den <= y_reg[rau_pkg::DEN_OUT_W-1:0];
          pk_st  <= rau_pkg::STAT_OK;
        end else begin
          pk_num <= '0;
          pk_den <= '0;
          pk_st  <= rau_pkg::STAT_OVF;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/rau_checker.sv @@
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks for the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rational_arithmetic_unit_top_defines.svh"

module rau_checker (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     s_tvalid,
  input wire logic                     s_tready,
  input wire logic [rau_pkg::IN_W-1:0] s_tdata,
  input wire logic                     m_tvalid,
  input wire logic                     m_tready,
  input wire logic [rau_pkg::OUT_W-1:0] m_tdata
);

  logic s_acc;
  assign s_acc = s_tvalid && s_tready;

  // a stalled result holds
  `RAU_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")

  // busy right after taking an item
  `RAU_ASSERT_NXT(a_busy, s_acc, !s_tready, "ready after accept")

  // error results carry 0/0
  `RAU_ASSERT_IMP(a_err_zero, m_tvalid && (m_tdata[65:64] == rau_pkg::STAT_ZERO), (m_tdata[62:0] == '0), "error result not cleared")

  // good results have a nonzero denominator; compare flag only with 0/1
  `RAU_ASSERT_IMP(a_ok_den, m_tvalid && (m_tdata[65:64] == rau_pkg::STAT_OK), (m_tdata[62:32] != '0) && (!m_tdata[63] || (m_tdata[62:0] == {31'd1, 32'd0})), "bad ok result")

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (.*);

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the rational arithmetic unit: a directed table of
// extremes and error cases, then random fractions, each result compared with
// a fixed answer or an exact predictor of reduce/add/sub/mul/div/compare and status.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM       = 700;

  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } op_t;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic        cmp;
    logic [1:0]  status;
  } answer_t;

  typedef struct {
    op_t     op;
    bit      fixed;
    answer_t ans;
  } row_t;

  logic                      clk = 0;
  logic                      rst = 1;
  logic                      s_tvalid = 0;
  logic                      s_tready;
  logic [rau_pkg::IN_W-1:0]  s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 0;
  logic [rau_pkg::OUT_W-1:0] m_tdata;

  answer_t pending_answers[$];
  int      error_count = 0;
  int      idle_cycles = 0;
  bit      stim_done = 0;
  bit      hold_off = 0;
  bit      no_idle = 0;
  row_t    table_rows[$];

  always #5 clk = ~clk;

  rational_arithmetic_unit_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // magnitude of a 32-bit two's complement field
  function automatic logic [63:0] mag64(logic [31:0] f);
    logic [31:0] m;
    m = f[31] ? -f : f;
    return {32'd0, m};
  endfunction

  // reduce nmag/dmag, sign given; zero numerator becomes 0/1
  function automatic void reduce_frac(input logic [63:0] nmag, input logic [63:0] dmag,
                                      output logic [63:0] rm, output logic [63:0] rd);
    logic [63:0] g;
    if (nmag == 0) begin
      rm = 0;
      rd = 1;
    end else begin
      g = gcd64(nmag, dmag);
      rm = nmag / g;
      rd = dmag / g;
    end
  endfunction

  function automatic answer_t rational_result(op_t op);
    answer_t r;
    logic an, ad, bn, bd, aneg, bneg, sneg, rneg, ok;
    logic [63:0] anm, adm, bnm, bdm, am, aden, bm, bden, p, q, nm, dm, rm, rd, lim;
    logic signed [63:0] x, y;
    r = '0;
    an = op.a_num[31]; anm = mag64(op.a_num);
    ad = op.a_den[31]; adm = mag64(op.a_den);
    bn = op.b_num[31]; bnm = mag64(op.b_num);
    bd = op.b_den[31]; bdm = mag64(op.b_den);
    if (op.mode > rau_pkg::MODE_LT || adm == 0 ||
        (op.mode != rau_pkg::MODE_REDUCE && bdm == 0)) begin
      r.status = rau_pkg::STAT_ZERO;
      return r;
    end
    reduce_frac(anm, adm, am, aden);
    aneg = (anm == 0) ? 1'b0 : an ^ ad;
    bm = am; bden = aden; bneg = aneg;
    if (op.mode != rau_pkg::MODE_REDUCE) begin
      reduce_frac(bnm, bdm, bm, bden);
      bneg = (bnm == 0) ? 1'b0 : bn ^ bd;
    end
    if (op.mode >= rau_pkg::MODE_EQ) begin
      x = aneg ? -$signed(am * bden) : $signed(am * bden);
      y = bneg ? -$signed(bm * aden) : $signed(bm * aden);
      case (op.mode)
        rau_pkg::MODE_EQ: r.cmp = (x == y);
        rau_pkg::MODE_NE: r.cmp = (x != y);
        rau_pkg::MODE_GT: r.cmp = (x > y);
        default:          r.cmp = (x < y);
      endcase
      r.den = 1;
      return r;
    end
    case (op.mode)
      rau_pkg::MODE_REDUCE: begin
        nm = am; dm = aden; sneg = aneg;
      end
      rau_pkg::MODE_ADD, rau_pkg::MODE_SUB: begin
        if (op.mode == rau_pkg::MODE_SUB) bneg = ~bneg;
        p = am * bden;
        q = bm * aden;
        if (aneg == bneg) begin
          sneg = aneg; nm = p + q;
        end else if (p >= q) begin
          sneg = aneg; nm = p - q;
        end else begin
          sneg = bneg; nm = q - p;
        end
        dm = aden * bden;
      end
      rau_pkg::MODE_MUL: begin
        sneg = aneg ^ bneg; nm = am * bm; dm = aden * bden;
      end
      default: begin
        if (bm == 0) begin
          r.status = rau_pkg::STAT_ZERO;
          return r;
        end
        sneg = aneg ^ bneg; nm = am * bden; dm = aden * bm;
      end
    endcase
    reduce_frac(nm, dm, rm, rd);
    rneg = (nm == 0) ? 1'b0 : sneg;
    lim = 64'd1 << 31;
    ok = (rd <= lim - 1) && (rneg ? (rm <= lim) : (rm <= lim - 1));
    if (!ok) begin
      r.status = rau_pkg::STAT_OVF;
      return r;
    end
    r.num = rneg ? 32'(-rm) : 32'(rm);
    r.den = 31'(rd);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 40)) - 20);
      3: return 32'($urandom_range(1, 1000)) * 32'($urandom_range(1, 30));
      4: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t rand_op();
    op_t op;
    op.mode  = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
    op.a_num = rand_field();
    op.b_num = rand_field();
    op.a_den = rand_field();
    op.b_den = rand_field();
    if (op.a_den == 0 && $urandom_range(0, 3) != 0) op.a_den = 1;
    if (op.b_den == 0 && $urandom_range(0, 3) != 0) op.b_den = 32'hffff_ffff;
    return op;
  endfunction

  function automatic void add_row(logic [3:0] m, logic [31:0] an, logic [31:0] ad,
                                  logic [31:0] bn, logic [31:0] bd, bit fx,
                                  answer_t a);
    row_t r;
    r.op = '{m, an, ad, bn, bd};
    r.fixed = fx;
    r.ans = a;
    table_rows.push_back(r);
  endfunction

  // called at a falling edge; s_tready only moves at rising edges
  task automatic send_item(op_t op, bit fixed, answer_t ans);
    while (!no_idle && $urandom_range(0, 99) < 24) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {4'd0, op.b_den, op.b_num, op.a_den, op.a_num, op.mode};
    pending_answers.push_back(fixed ? ans : rational_result(op));
    while (!s_tready) @(negedge clk);
    @(negedge clk);
  endtask

  // sender
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    add_row(rau_pkg::MODE_REDUCE, 6, 4, 0, 0, 1, '{32'd3, 31'd2, 1'b0, rau_pkg::STAT_OK});
    add_row(rau_pkg::MODE_REDUCE, 0, -7, 0, 0, 1, '{32'd0, 31'd1, 1'b0, rau_pkg::STAT_OK});
    add_row(rau_pkg::MODE_REDUCE, 5, 0, 1, 1, 1, '{0, 0, 1'b0, rau_pkg::STAT_ZERO});
    add_row(rau_pkg::MODE_ADD, 1, 2, 1, 0, 1, '{0, 0, 1'b0, rau_pkg::STAT_ZERO});
    add_row(rau_pkg::MODE_DIV, 1, 2, 0, 3, 1, '{0, 0, 1'b0, rau_pkg::STAT_ZERO});
    add_row(4'd9, 1, 1, 1, 1, 1, '{0, 0, 1'b0, rau_pkg::STAT_ZERO});
    add_row(4'd15, 1, 1, 1, 1, 1, '{0, 0, 1'b0, rau_pkg::STAT_ZERO});
    add_row(rau_pkg::MODE_REDUCE, 32'h8000_0000, -1, 0, 0, 1,
            '{0, 0, 1'b0, rau_pkg::STAT_OVF});
    add_row(rau_pkg::MODE_REDUCE, 32'h8000_0000, 1, 0, 0, 1,
            '{32'h8000_0000, 31'd1, 1'b0, rau_pkg::STAT_OK});
    add_row(rau_pkg::MODE_REDUCE, 1, 32'h8000_0000, 0, 0, 1,
            '{0, 0, 1'b0, rau_pkg::STAT_OVF});
    add_row(rau_pkg::MODE_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1, 0, '0);
    add_row(rau_pkg::MODE_ADD, 1, 3, 1, 6, 0, '0);
    add_row(rau_pkg::MODE_SUB, 1, 3, 1, 3, 0, '0);
    add_row(rau_pkg::MODE_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
            0, '0);
    add_row(rau_pkg::MODE_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1, 0, '0);
    add_row(rau_pkg::MODE_MUL, -3, 7, 7, -3, 0, '0);
    add_row(rau_pkg::MODE_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
            0, '0);
    add_row(rau_pkg::MODE_EQ, 1, 2, -2, -4, 1, '{0, 31'd1, 1'b1, rau_pkg::STAT_OK});
    add_row(rau_pkg::MODE_NE, 1, 2, 2, 4, 1, '{0, 31'd1, 1'b0, rau_pkg::STAT_OK});
    add_row(rau_pkg::MODE_GT, 1, 2, 1, 3, 1, '{0, 31'd1, 1'b1, rau_pkg::STAT_OK});
    add_row(rau_pkg::MODE_LT, -1, 2, 1, 3, 1, '{0, 31'd1, 1'b1, rau_pkg::STAT_OK});
    add_row(rau_pkg::MODE_LT, 32'h8000_0000, 1, 32'h7fff_ffff, 32'h8000_0000, 0, '0);
    foreach (table_rows[i]) send_item(table_rows[i].op, table_rows[i].fixed,
                                      table_rows[i].ans);
    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 300 && i < 400);
      hold_off = (i >= 450 && i < 460);
      send_item(rand_op(), 0, '0);
    end
    s_tvalid <= 0;
    stim_done = 1;
  end

  // receiver: random stalls, one long hold-off while items keep coming
  initial begin
    int hold;
    bit hold_used;
    hold = 0;
    hold_used = 0;
    forever begin
      @(negedge clk);
      if (hold_off && !hold_used) begin
        hold = 3000;
        hold_used = 1;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 0;
      end else begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  // result check
  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.num    = m_tdata[31:0];
      got.den    = m_tdata[62:32];
      got.cmp    = m_tdata[63];
      got.status = m_tdata[65:64];
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected item", 64'(got), 0);
      end else begin
        want = pending_answers.pop_front();
        if (got.num != want.num) report_mismatch("res_num", got.num, want.num);
        if (got.den != want.den) report_mismatch("res_den", got.den, want.den);
        if (got.cmp != want.cmp) report_mismatch("compare_true", got.cmp, want.cmp);
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
      end
    end
  end

  // watchdog and end of run
  initial begin
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout");
        $display("FAILED: results differ");
        $finish;
      end
      if (stim_done && pending_answers.size() == 0) begin
        repeat (1200) @(posedge clk);
        if (error_count == 0 && pending_answers.size() == 0) begin
          $display("PASSED: all results match");
        end else begin
          $display("FAILED: results differ");
        end
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
